// File: design/http_request_head_parser_macros.svh
// ---------------------------------------------------------------------------
// HTTP request head parser assertion macros
// Shared concurrent assertion forms used by the parser back end.
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define HRHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hrhp: same-cycle check failed");

// next-cycle implication, checked outside reset
`define HRHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hrhp: next-cycle check failed");

`endif

// File: design/hrhp_pkg.sv
// ---------------------------------------------------------------------------
// HTTP request head parser package
// Character constants, role/status/method codes and the classified byte type.
// ---------------------------------------------------------------------------
package hrhp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;

    localparam int NUM_METH = 3;
    localparam int METH_MAX = 4;
    localparam int VER_PFX_LEN = 7;

    // GET, POST, HEAD; unused tail of GET never compared
    localparam logic [0:NUM_METH-1][0:METH_MAX-1][7:0] METH_TEXT = '{
        '{8'h47, 8'h45, 8'h54, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54},
        '{8'h48, 8'h45, 8'h41, 8'h44}
    };
    localparam logic [0:NUM_METH-1][3:0] METH_LEN = '{4'd3, 4'd4, 4'd4};

    localparam logic [0:VER_PFX_LEN-1][7:0] VER_PREFIX = "HTTP/1.";
    localparam logic [3:0] VER_LEN = 4'd8;

    // byte roles
    localparam logic [2:0] ROLE_METHOD = 3'd0;
    localparam logic [2:0] ROLE_PATH   = 3'd1;
    localparam logic [2:0] ROLE_QUERY  = 3'd2;
    localparam logic [2:0] ROLE_VER    = 3'd3;
    localparam logic [2:0] ROLE_HNAME  = 3'd4;
    localparam logic [2:0] ROLE_HVAL   = 3'd5;
    localparam logic [2:0] ROLE_SEP    = 3'd6;
    localparam logic [2:0] ROLE_BODY   = 3'd7;

    localparam logic [1:0] STAT_BUSY = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    localparam logic [1:0] METH_NONE = 2'd0;
    localparam logic [1:0] METH_GET  = 2'd1;
    localparam logic [1:0] METH_POST = 2'd2;
    localparam logic [1:0] METH_HEAD = 2'd3;

    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_10   = 2'd1;
    localparam logic [1:0] VER_11   = 2'd2;

    // byte plus its precomputed character classes
    typedef struct packed {
        logic [7:0]                               data;
        logic                                     last;
        logic                                     is_cr;
        logic                                     is_lf;
        logic                                     is_space;
        logic                                     is_qmark;
        logic                                     is_colon;
        logic                                     is_zero;
        logic                                     is_one;
        logic [NUM_METH-1:0][METH_MAX-1:0]        meth_match;
        logic [VER_PFX_LEN-1:0]                   ver_match;
    } t_class;

endpackage

// File: design/hrhp_front.sv
// ---------------------------------------------------------------------------
// HTTP request head parser front end
// Accepts input bytes and tags them with character classes for the parser.
// ---------------------------------------------------------------------------
module hrhp_front
    import hrhp_pkg::*;
(
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_class     o_item
);

    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_item          = '0;
        o_item.data     = i_data_byte;
        o_item.last     = i_last_byte;
        o_item.is_cr    = (i_data_byte == CH_CR);
        o_item.is_lf    = (i_data_byte == CH_LF);
        o_item.is_space = (i_data_byte == CH_SP);
        o_item.is_qmark = (i_data_byte == CH_QMARK);
        o_item.is_colon = (i_data_byte == CH_COLON);
        o_item.is_zero  = (i_data_byte == CH_ZERO);
        o_item.is_one   = (i_data_byte == CH_ONE);
        for (int k = 0; k < NUM_METH; k++) begin
            for (int p = 0; p < METH_MAX; p++) begin
                o_item.meth_match[k][p] = (i_data_byte == METH_TEXT[k][p]);
            end
        end
        for (int p = 0; p < VER_PFX_LEN; p++) begin
            o_item.ver_match[p] = (i_data_byte == VER_PREFIX[p]);
        end
    end

endmodule

// File: design/hrhp_queue.sv
// ---------------------------------------------------------------------------
// HTTP request head parser queue
// Small FIFO of classified bytes between the front end and the parser.
// ---------------------------------------------------------------------------
module hrhp_queue
    import hrhp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_item,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_nonempty,
    output t_class o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_class          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;
    logic            do_push, do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_item     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/hrhp_back.sv
// ---------------------------------------------------------------------------
// HTTP request head parser back end
// Parse state machine over classified bytes, with a registered result stage.
// ---------------------------------------------------------------------------
`include "http_request_head_parser_macros.svh"

module hrhp_back
    import hrhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_nonempty,
    input  t_class     i_item,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_role,
    output logic [1:0] o_parse_status,
    output logic [1:0] o_method_code,
    output logic [1:0] o_version_code,
    output logic       o_line_done,
    output logic       o_message_done
);

    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_PATH    = 3'd1;
    localparam logic [2:0] PH_QUERY   = 3'd2;
    localparam logic [2:0] PH_VERSION = 3'd3;
    localparam logic [2:0] PH_HNAME   = 3'd4;
    localparam logic [2:0] PH_HVALUE  = 3'd5;
    localparam logic [2:0] PH_BODY    = 3'd6;

    localparam logic [2:0] CAND_ALL = 3'b111;
    localparam logic [3:0] METH_POS_MAX = 4'd8;
    localparam logic [3:0] VER_POS_MAX  = 4'd9;
    localparam logic [3:0] VER_LAST_POS = 4'(VER_PFX_LEN);

    logic [2:0] r_phase, n_phase;
    logic [3:0] r_pos,   n_pos;
    logic [2:0] r_cand,  n_cand;
    logic [1:0] r_meth,  n_meth;
    logic [1:0] r_ver,   n_ver;
    logic       r_colon, n_colon;
    logic       r_empty, n_empty;
    logic       r_crp,   n_crp;
    logic       r_err,   n_err;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte;
    logic [2:0] r_role;
    logic [1:0] r_status;
    logic [1:0] r_meth_out;
    logic [1:0] r_ver_out;
    logic       r_ldone;
    logic       r_last;

    logic [2:0] role;
    logic       ldone;
    logic [1:0] status;
    logic       pop;

    assign pop   = i_q_nonempty && (!r_out_valid || !i_stall);
    assign o_pop = pop;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cand  = r_cand;
        n_meth  = r_meth;
        n_ver   = r_ver;
        n_colon = r_colon;
        n_empty = r_empty;
        n_crp   = r_crp;
        n_err   = r_err;
        role    = ROLE_BODY;
        ldone   = 1'b0;

        if (r_phase == PH_BODY) begin
            role = ROLE_BODY;
        end else if (r_crp && i_item.is_lf) begin
            // CRLF closes the current line
            n_crp = 1'b0;
            ldone = 1'b1;
            role  = ROLE_SEP;
            unique case (r_phase)
                PH_METHOD, PH_PATH, PH_QUERY: begin
                    n_err = 1'b1;
                end
                PH_VERSION: begin
                    if (r_pos != VER_LEN) begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    if (!r_empty && !r_colon) begin
                        n_err = 1'b1;
                    end
                end
            endcase
            if ((r_phase == PH_HNAME || r_phase == PH_HVALUE) && r_empty) begin
                n_phase = PH_BODY;
            end else begin
                n_phase = PH_HNAME;
                n_pos   = '0;
                n_colon = 1'b0;
                n_empty = 1'b1;
            end
        end else begin
            if (r_crp) begin
                // CR without LF
                n_crp = 1'b0;
                n_err = 1'b1;
            end
            if (i_item.is_cr) begin
                n_crp = 1'b1;
                role  = ROLE_SEP;
            end else begin
                unique case (r_phase)
                    PH_METHOD: begin
                        if (i_item.is_space) begin
                            priority if (r_pos == METH_LEN[2] && r_cand[2]) begin
                                n_meth = METH_HEAD;
                            end else if (r_pos == METH_LEN[1] && r_cand[1]) begin
                                n_meth = METH_POST;
                            end else if (r_pos == METH_LEN[0] && r_cand[0]) begin
                                n_meth = METH_GET;
                            end else begin
                                n_meth = METH_NONE;
                            end
                            if (n_meth == METH_NONE) begin
                                n_err = 1'b1;
                            end
                            n_phase = PH_PATH;
                            n_pos   = '0;
                            role    = ROLE_SEP;
                        end else begin
                            for (int k = 0; k < NUM_METH; k++) begin
                                if (!(r_pos < METH_LEN[k] && i_item.meth_match[k][r_pos[1:0]]))
                                begin
                                    n_cand[k] = 1'b0;
                                end
                            end
                            if (r_pos < METH_POS_MAX) begin
                                n_pos = r_pos + 1'b1;
                            end
                            role = ROLE_METHOD;
                        end
                    end
                    PH_PATH, PH_QUERY: begin
                        if (i_item.is_space) begin
                            n_phase = PH_VERSION;
                            n_pos   = '0;
                            role    = ROLE_SEP;
                        end else if (i_item.is_qmark || r_phase == PH_QUERY) begin
                            n_phase = PH_QUERY;
                            role    = ROLE_QUERY;
                        end else begin
                            role = ROLE_PATH;
                        end
                    end
                    PH_VERSION: begin
                        if (r_pos < VER_LAST_POS) begin
                            if (!i_item.ver_match[r_pos[2:0]]) begin
                                n_err = 1'b1;
                            end
                        end else if (r_pos == VER_LAST_POS) begin
                            priority if (i_item.is_one) begin
                                n_ver = VER_11;
                            end else if (i_item.is_zero) begin
                                n_ver = VER_10;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                        if (r_pos < VER_POS_MAX) begin
                            n_pos = r_pos + 1'b1;
                        end
                        role = ROLE_VER;
                    end
                    PH_HNAME: begin
                        n_empty = 1'b0;
                        if (i_item.is_colon) begin
                            n_colon = 1'b1;
                            n_phase = PH_HVALUE;
                            role    = ROLE_SEP;
                        end else begin
                            role = ROLE_HNAME;
                        end
                    end
                    default: begin
                        n_empty = 1'b0;
                        role    = ROLE_HVAL;
                    end
                endcase
            end
        end

        status = n_err ? STAT_ERR : STAT_BUSY;
        if (i_item.last) begin
            status = (!n_err && (ldone || n_phase == PH_BODY)) ? STAT_OK : STAT_ERR;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (pop) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_METHOD;
            r_pos       <= '0;
            r_cand      <= CAND_ALL;
            r_meth      <= METH_NONE;
            r_ver       <= VER_NONE;
            r_colon     <= 1'b0;
            r_empty     <= 1'b1;
            r_crp       <= 1'b0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                if (i_item.last) begin
                    // message over: start fresh for the next one
                    r_phase <= PH_METHOD;
                    r_pos   <= '0;
                    r_cand  <= CAND_ALL;
                    r_meth  <= METH_NONE;
                    r_ver   <= VER_NONE;
                    r_colon <= 1'b0;
                    r_empty <= 1'b1;
                    r_crp   <= 1'b0;
                    r_err   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_pos   <= n_pos;
                    r_cand  <= n_cand;
                    r_meth  <= n_meth;
                    r_ver   <= n_ver;
                    r_colon <= n_colon;
                    r_empty <= n_empty;
                    r_crp   <= n_crp;
                    r_err   <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_byte     <= i_item.data;
            r_role     <= role;
            r_status   <= status;
            r_meth_out <= n_meth;
            r_ver_out  <= n_ver;
            r_ldone    <= ldone;
            r_last     <= i_item.last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_out     = r_byte;
    assign o_byte_role    = r_role;
    assign o_parse_status = r_status;
    assign o_method_code  = r_meth_out;
    assign o_version_code = r_ver_out;
    assign o_line_done    = r_ldone;
    assign o_message_done = r_last;

    `HRHP_ASSERT_NOW(a_ldone_is_lf, i_clk, i_rst_n, o_valid && o_line_done, o_byte_out == CH_LF)
    `HRHP_ASSERT_NOW(a_ok_only_at_end, i_clk, i_rst_n,
        o_valid && (o_parse_status == STAT_OK), o_message_done)
    `HRHP_ASSERT_NOW(a_body_no_cr, i_clk, i_rst_n, r_phase == PH_BODY, !r_crp)
    `HRHP_ASSERT_NEXT(a_reset_after_last, i_clk, i_rst_n, pop && i_item.last,
        (r_phase == PH_METHOD) && (r_cand == CAND_ALL) && !r_err)

endmodule

// File: design/http_request_head_parser.sv
// ---------------------------------------------------------------------------
// HTTP request head parser
// Tags each byte of an HTTP/1.x request buffer with its role and checks the
// method, version and header syntax; the verdict is final on the last byte.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while neither side stalls and returns one result
// per byte, in order. A byte passes through a classifier, a QUEUE_DEPTH-entry
// queue and the parse state machine, which updates once per byte; results
// leave from an output register after the queue, and sustained throughput is
// one transaction per cycle while unstalled. While the output is stalled the
// queue fills up to QUEUE_DEPTH transactions behind the output register; the
// input stalls once the queue is full.
// All parse state clears after the byte flagged as last.
module http_request_head_parser
    import hrhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_byte_role,
    output logic [1:0] o_parse_status,
    output logic [1:0] o_method_code,
    output logic [1:0] o_version_code,
    output logic       o_line_done,
    output logic       o_message_done
);

    t_class front_item;
    t_class queue_item;
    logic   q_full;
    logic   q_nonempty;
    logic   push;
    logic   pop;

    hrhp_front u_front (
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (front_item)
    );

    hrhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_item     (queue_item)
    );

    hrhp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (q_nonempty),
        .i_item         (queue_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_out     (o_byte_out),
        .o_byte_role    (o_byte_role),
        .o_parse_status (o_parse_status),
        .o_method_code  (o_method_code),
        .o_version_code (o_version_code),
        .o_line_done    (o_line_done),
        .o_message_done (o_message_done)
    );

endmodule
